### sv/tpk_pkg.sv
// ----------------------------------------------------------------------------
// tpk_pkg
// Shared types and constants of the peak search with exclusion zone.
// ----------------------------------------------------------------------------
package tpk_pkg;

    localparam int POS_BITS        = 14;
    localparam int PEAK_COUNT_BITS = 5;
    localparam int DEADZONE_BITS   = 14;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 14;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK_COUNT = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEADZONE   = CFG_INDEX_BITS'(1);

    localparam logic [PEAK_COUNT_BITS-1:0] PEAK_COUNT_RESET = PEAK_COUNT_BITS'(10);
    localparam logic [DEADZONE_BITS-1:0]   DEADZONE_RESET   = DEADZONE_BITS'(100);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FLUSH,
        ST_COMMIT,
        ST_EMIT
    } tpk_state_t;

    typedef struct packed {
        logic clear_list;
        logic scan_en;
        logic commit;
        logic shift;
    } tpk_cmd_t;

endpackage

### sv/tpk_sample_ram.sv
// ----------------------------------------------------------------------------
// tpk_sample_ram
// Acquisition buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpk_sample_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 14,
    parameter int AW    = 14
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/tpk_datapath.sv
// ----------------------------------------------------------------------------
// tpk_datapath
// Exclusion check, running maximum of one pass and the sorted peak list.
// ----------------------------------------------------------------------------
module tpk_datapath import tpk_pkg::*; #(
    parameter int SAMPLE_DEPTH = 16384,
    parameter int MAX_PEAKS    = 16,
    parameter int SAMPLE_BITS  = 14,
    localparam int AW = $clog2(SAMPLE_DEPTH),
    localparam int DW = (AW > DEADZONE_BITS) ? AW : DEADZONE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tpk_cmd_t                      cmd,
    input  logic [AW-1:0]                 scan_addr,
    input  logic [DEADZONE_BITS-1:0]      deadzone,
    input  logic signed [SAMPLE_BITS-1:0] ram_rdata,
    output logic [POS_BITS-1:0]           peak_pos,
    output logic signed [SAMPLE_BITS-1:0] peak_value,
    output logic                          peak_found
);

    logic [AW-1:0]                 cell_pos_reg [MAX_PEAKS];
    logic signed [SAMPLE_BITS-1:0] cell_val_reg [MAX_PEAKS];
    logic                          cell_fnd_reg [MAX_PEAKS];
    logic                          cell_vld_reg [MAX_PEAKS];
    logic                          gt           [MAX_PEAKS];

    logic [MAX_PEAKS-1:0]          excl_vec;
    logic [MAX_PEAKS-1:0]          excl_reg;
    logic [AW-1:0]                 stage_pos_reg;
    logic                          stage_vld_reg;

    logic signed [SAMPLE_BITS-1:0] best_val_reg;
    logic [AW-1:0]                 best_pos_reg;
    logic                          best_hit_reg;
    logic                          take;

    always_comb begin
        for (int j = 0; j < MAX_PEAKS; j++) begin
            excl_vec[j] = cell_vld_reg[j] &&
                (DW'((scan_addr >= cell_pos_reg[j]) ? (scan_addr - cell_pos_reg[j])
                                                     : (cell_pos_reg[j] - scan_addr))
                 < DW'(deadzone));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg <= 1'b0;
        end else begin
            stage_vld_reg <= cmd.scan_en;
        end
    end

    always_ff @(posedge aclk) begin
        excl_reg      <= excl_vec;
        stage_pos_reg <= scan_addr;
    end

    assign take = stage_vld_reg && !(|excl_reg) && (ram_rdata > best_val_reg);

    always_ff @(posedge aclk) begin
        if (cmd.clear_list || cmd.commit) begin
            best_val_reg <= '0;
            best_pos_reg <= '0;
            best_hit_reg <= 1'b0;
        end else if (take) begin
            best_val_reg <= ram_rdata;
            best_pos_reg <= stage_pos_reg;
            best_hit_reg <= 1'b1;
        end
    end

    for (genvar i = 0; i < MAX_PEAKS; i++) begin : g_cell
        logic                          prev_gt;
        logic                          prev_vld;
        logic [AW-1:0]                 prev_pos;
        logic signed [SAMPLE_BITS-1:0] prev_val;
        logic                          prev_fnd;
        logic                          nxt_vld;
        logic [AW-1:0]                 nxt_pos;
        logic signed [SAMPLE_BITS-1:0] nxt_val;
        logic                          nxt_fnd;

        assign gt[i] = !cell_vld_reg[i] || (cell_pos_reg[i] > best_pos_reg);

        if (i == 0) begin : g_head
            assign prev_gt  = 1'b0;
            assign prev_vld = 1'b1;
            assign prev_pos = best_pos_reg;
            assign prev_val = best_val_reg;
            assign prev_fnd = best_hit_reg;
        end else begin : g_body
            assign prev_gt  = gt[i-1];
            assign prev_vld = cell_vld_reg[i-1];
            assign prev_pos = cell_pos_reg[i-1];
            assign prev_val = cell_val_reg[i-1];
            assign prev_fnd = cell_fnd_reg[i-1];
        end

        if (i == MAX_PEAKS - 1) begin : g_tail
            assign nxt_vld = 1'b0;
            assign nxt_pos = cell_pos_reg[i];
            assign nxt_val = cell_val_reg[i];
            assign nxt_fnd = cell_fnd_reg[i];
        end else begin : g_link
            assign nxt_vld = cell_vld_reg[i+1];
            assign nxt_pos = cell_pos_reg[i+1];
            assign nxt_val = cell_val_reg[i+1];
            assign nxt_fnd = cell_fnd_reg[i+1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cell_vld_reg[i] <= 1'b0;
            end else if (cmd.clear_list) begin
                cell_vld_reg[i] <= 1'b0;
            end else if (cmd.commit && gt[i]) begin
                cell_vld_reg[i] <= prev_gt ? prev_vld : 1'b1;
            end else if (cmd.shift) begin
                cell_vld_reg[i] <= nxt_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.commit && gt[i]) begin
                cell_pos_reg[i] <= prev_gt ? prev_pos : best_pos_reg;
                cell_val_reg[i] <= prev_gt ? prev_val : best_val_reg;
                cell_fnd_reg[i] <= prev_gt ? prev_fnd : best_hit_reg;
            end else if (cmd.shift) begin
                cell_pos_reg[i] <= nxt_pos;
                cell_val_reg[i] <= nxt_val;
                cell_fnd_reg[i] <= nxt_fnd;
            end
        end
    end

    assign peak_pos   = POS_BITS'(cell_pos_reg[0]);
    assign peak_value = cell_val_reg[0];
    assign peak_found = cell_fnd_reg[0];

endmodule

### sv/tpk_ctrl.sv
// ----------------------------------------------------------------------------
// tpk_ctrl
// Sequencer: buffer fill, one scan per peak, list commit and result drain.
// ----------------------------------------------------------------------------
module tpk_ctrl import tpk_pkg::*; #(
    parameter int SAMPLE_DEPTH = 16384,
    parameter int MAX_PEAKS    = 16,
    localparam int AW = $clog2(SAMPLE_DEPTH),
    localparam int CW = $clog2(SAMPLE_DEPTH + 1),
    localparam int PW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1,
    localparam int NW = $clog2(MAX_PEAKS + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_last,
    output logic                       s_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_last,
    input  logic [PEAK_COUNT_BITS-1:0] peak_count,
    output logic                       ram_we,
    output logic [AW-1:0]              ram_waddr,
    output logic [AW-1:0]              scan_addr,
    output tpk_cmd_t                   cmd
);

    tpk_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg,   idx_next;
    logic [PW-1:0] pass_reg,  pass_next;
    logic [PW-1:0] emit_reg,  emit_next;
    logic [NW-1:0] n_reg,     n_next;
    logic          pend_reg,  pend_next;

    logic          s_xfer;
    logic          s_last_xfer;
    logic          m_xfer;
    logic          scan_end;
    logic          pass_end;
    logic          emit_end;
    logic          start;
    logic [NW-1:0] n_clamp;

    assign s_ready     = (state_reg == ST_LOAD) || ((state_reg == ST_EMIT) && !pend_reg);
    assign m_valid     = (state_reg == ST_EMIT);
    assign s_xfer      = s_valid && s_ready;
    assign s_last_xfer = s_xfer && s_last;
    assign m_xfer      = m_valid && m_ready;

    assign ram_we    = s_xfer && (count_reg < CW'(SAMPLE_DEPTH));
    assign ram_waddr = count_reg[AW-1:0];
    assign scan_addr = idx_reg;

    assign scan_end = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign pass_end = (NW'(pass_reg) + NW'(1)) == n_reg;
    assign emit_end = (NW'(emit_reg) + NW'(1)) == n_reg;
    assign m_last   = emit_end;

    always_comb begin
        if (peak_count == '0) begin
            n_clamp = NW'(1);
        end else if (int'(peak_count) > MAX_PEAKS) begin
            n_clamp = NW'(MAX_PEAKS);
        end else begin
            n_clamp = NW'(peak_count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            idx_reg   <= '0;
            pass_reg  <= '0;
            emit_reg  <= '0;
            n_reg     <= NW'(1);
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            emit_reg  <= emit_next;
            n_reg     <= n_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = ram_we ? count_reg + CW'(1) : count_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        emit_next  = emit_reg;
        n_next     = n_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        start      = 1'b0;

        unique case (state_reg)
            ST_LOAD: begin
                start = s_last_xfer;
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (scan_end) begin
                    state_next = ST_FLUSH;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_FLUSH: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                if (pass_end) begin
                    state_next = ST_EMIT;
                    emit_next  = '0;
                    count_next = '0;
                end else begin
                    pass_next  = pass_reg + PW'(1);
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT: begin
                if (s_last_xfer) begin
                    pend_next = 1'b1;
                end
                if (m_xfer) begin
                    cmd.shift = 1'b1;
                    if (emit_end) begin
                        if (pend_reg || s_last_xfer) begin
                            start = 1'b1;
                        end else begin
                            state_next = ST_LOAD;
                        end
                    end else begin
                        emit_next = emit_reg + PW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (start) begin
            state_next     = ST_SCAN;
            idx_next       = '0;
            pass_next      = '0;
            n_next         = n_clamp;
            pend_next      = 1'b0;
            cmd.clear_list = 1'b1;
        end
    end

    a_no_load_while_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_en |-> !s_ready)
        else $error("input accepted during a scan pass");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(SAMPLE_DEPTH))
        else $error("sample count beyond buffer depth");

    a_emit_after_last_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT) && pass_end |=> m_valid && (emit_reg == '0))
        else $error("results not presented after final pass");

endmodule

### sv/top_peaks_with_exclusion_zone_core.sv
// ----------------------------------------------------------------------------
// top_peaks_with_exclusion_zone_core
// Top-k peak search with exclusion zone over one acquisition buffer.
// ----------------------------------------------------------------------------
// Samples stream in at one per cycle until the transfer marked tlast; samples
// past SAMPLE_DEPTH are dropped. The block then runs n = peak_count passes
// (clamped to 1..MAX_PEAKS) over the stored samples, each pass reading the
// single read port of the sample memory once per sample and then flushing and
// committing its result. Each pass keeps the first strictly greatest
// sample above zero outside the deadzone of the peaks already found and
// inserts it into a position-sorted list. The n results then leave in
// ascending position order, one per cycle while m_tready is high, the last
// one with m_tlast; samples of the next buffer are taken during that drain.
// ----------------------------------------------------------------------------
module top_peaks_with_exclusion_zone_core import tpk_pkg::*; #(
    parameter int SAMPLE_DEPTH = 16384,
    parameter int MAX_PEAKS    = 16,
    parameter int SAMPLE_BITS  = 14
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // s_tdata: sample
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]   s_tdata,
    input  logic                                       s_tlast,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // m_tdata: peak_position, peak_value
    output logic [((POS_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // m_tuser: peak_found
    output logic                                       m_tuser,
    output logic                                       m_tlast,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]                  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                   cfg_data
);

    localparam int AW    = $clog2(SAMPLE_DEPTH);
    localparam int OUT_W = ((POS_BITS + SAMPLE_BITS + 7) / 8) * 8;

    logic [PEAK_COUNT_BITS-1:0]    peak_count_reg;
    logic [DEADZONE_BITS-1:0]      deadzone_reg;

    tpk_cmd_t                      cmd;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [AW-1:0]                 scan_addr;
    logic signed [SAMPLE_BITS-1:0] ram_rdata;
    logic [POS_BITS-1:0]           peak_pos;
    logic signed [SAMPLE_BITS-1:0] peak_value;
    logic                          peak_found;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_count_reg <= PEAK_COUNT_RESET;
            deadzone_reg   <= DEADZONE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_PEAK_COUNT) begin
                peak_count_reg <= cfg_data[PEAK_COUNT_BITS-1:0];
            end else if (cfg_index == CFG_DEADZONE) begin
                deadzone_reg <= cfg_data[DEADZONE_BITS-1:0];
            end
        end
    end

    tpk_ctrl #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .MAX_PEAKS    (MAX_PEAKS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_last     (s_tlast),
        .s_ready    (s_tready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_last     (m_tlast),
        .peak_count (peak_count_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .scan_addr  (scan_addr),
        .cmd        (cmd)
    );

    tpk_sample_ram #(
        .DEPTH (SAMPLE_DEPTH),
        .WIDTH (SAMPLE_BITS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_tdata[SAMPLE_BITS-1:0]),
        .rd_en   (cmd.scan_en),
        .rd_addr (scan_addr),
        .rd_data (ram_rdata)
    );

    tpk_datapath #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .MAX_PEAKS    (MAX_PEAKS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .scan_addr  (scan_addr),
        .deadzone   (deadzone_reg),
        .ram_rdata  (ram_rdata),
        .peak_pos   (peak_pos),
        .peak_value (peak_value),
        .peak_found (peak_found)
    );

    assign m_tdata = OUT_W'({peak_value, peak_pos});
    assign m_tuser = peak_found;

endmodule

### tb/tb_top_peaks_with_exclusion_zone_core.sv
// ----------------------------------------------------------------------------
// tb_top_peaks_with_exclusion_zone_core
// Self-checking regression for the top-k peak search with exclusion zone.
// ----------------------------------------------------------------------------
// Sample buffers stream into the block with random gaps while the result side
// stalls at random. A behavioral model of the search, sort and drain tracks
// every accepted sample and queues the peaks that each tlast transfer must
// produce; every result transfer is checked field by field against the oldest
// queued peak. Directed buffers cover reset settings, field extremes, ties,
// deadzone corners and peak count clamping; random buffers then run under a
// series of register settings.
// ----------------------------------------------------------------------------
module tb_top_peaks_with_exclusion_zone_core;
    import tpk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16384;
    localparam int MAXP        = 16;
    localparam int SBITS       = 14;
    localparam int S_W         = ((SBITS + 7) / 8) * 8;
    localparam int M_W         = ((POS_BITS + SBITS + 7) / 8) * 8;
    localparam int STALL_LIMIT = 400000;

    typedef struct {
        logic [POS_BITS-1:0]     pos;
        logic signed [SBITS-1:0] val;
        logic                    hit;
        logic                    is_last;
    } peak_t;

    logic                      aclk;
    logic                      aresetn;
    logic [S_W-1:0]            s_tdata;
    logic                      s_tlast;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [M_W-1:0]            m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;
    logic                      m_tvalid;
    logic                      m_tready;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    logic signed [SBITS-1:0] acq_buf [DEPTH];
    int    acq_len;
    int    shadow_count;
    int    shadow_zone;
    peak_t peaks_due[$];
    peak_t want;
    int    pattern[$];

    bit idle_on = 1'b1;
    int rx_hold = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int n_samples = 0;
    int n_results = 0;
    int n_buffers = 0;
    int n_settings = 0;

    top_peaks_with_exclusion_zone_core #(
        .SAMPLE_DEPTH (DEPTH),
        .MAX_PEAKS    (MAXP),
        .SAMPLE_BITS  (SBITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic void locate_peaks();
        peak_t found [MAXP];
        peak_t tmp;
        int n, p, s, k, j, d;
        int best_pos;
        logic signed [SBITS-1:0] best_val;
        bit hit, blocked;
        n = shadow_count;
        if (n < 1) begin
            n = 1;
        end
        if (n > MAXP) begin
            n = MAXP;
        end
        for (p = 0; p < n; p++) begin
            best_pos = 0;
            best_val = '0;
            hit = 1'b0;
            for (s = 0; s < acq_len; s++) begin
                blocked = 1'b0;
                for (k = 0; k < p; k++) begin
                    d = s - int'(found[k].pos);
                    if (d < 0) begin
                        d = -d;
                    end
                    if (d < shadow_zone) begin
                        blocked = 1'b1;
                    end
                end
                if (!blocked && acq_buf[s] > best_val) begin
                    best_val = acq_buf[s];
                    best_pos = s;
                    hit = 1'b1;
                end
            end
            found[p] = '{pos: POS_BITS'(best_pos), val: best_val, hit: hit, is_last: 1'b0};
        end
        for (p = 1; p < n; p++) begin
            tmp = found[p];
            j = p;
            while (j > 0 && found[j-1].pos > tmp.pos) begin
                found[j] = found[j-1];
                j--;
            end
            found[j] = tmp;
        end
        for (k = 0; k < n; k++) begin
            found[k].is_last = (k == n - 1);
            peaks_due.push_back(found[k]);
        end
    endfunction

    function automatic void take_sample(input logic [SBITS-1:0] raw, input logic is_last);
        if (acq_len < DEPTH) begin
            acq_buf[acq_len] = $signed(raw);
            acq_len++;
        end
        n_samples++;
        if (is_last) begin
            locate_peaks();
            acq_len = 0;
            n_buffers++;
        end
    endfunction

    // check results first, then record the sample taken at the same edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (peaks_due.size() == 0) begin
                flag_error($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                                     m_tdata, m_tuser, m_tlast));
            end else begin
                want = peaks_due.pop_front();
                if (m_tdata[POS_BITS-1:0] !== want.pos
                        || m_tdata[POS_BITS+SBITS-1:POS_BITS] !== want.val
                        || m_tuser !== want.hit || m_tlast !== want.is_last) begin
                    flag_error($sformatf({"peak mismatch: expected pos=%0d val=%0d found=%b ",
                                          "last=%b, got pos=%0d val=%0d found=%b last=%b"},
                                         want.pos, want.val, want.hit, want.is_last,
                                         m_tdata[POS_BITS-1:0],
                                         $signed(m_tdata[POS_BITS+SBITS-1:POS_BITS]),
                                         m_tuser, m_tlast));
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            take_sample(s_tdata[SBITS-1:0], s_tlast);
        end
    end

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_sample(input logic [SBITS-1:0] v, input bit is_last);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= S_W'(v);
        s_tlast  <= is_last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_run();
        int i;
        for (i = 0; i < pattern.size(); i++) begin
            send_sample(SBITS'(pattern[i]), i == pattern.size() - 1);
        end
    endtask

    task automatic send_buffer(input int len, input int style);
        int i, v;
        for (i = 0; i < len; i++) begin
            case (style)
                0: v = $urandom_range(0, 16383) - 8192;
                1: begin
                    if ($urandom_range(0, 4) == 0) begin
                        v = $urandom_range(1, 8191);
                    end else begin
                        v = -$urandom_range(0, 8192);
                    end
                end
                2: v = $urandom_range(0, 6) - 3;
                default: v = -$urandom_range(0, 8192);
            endcase
            send_sample(SBITS'(v), i == len - 1);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (peaks_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_regs(input int count, input int zone);
        cfg_index <= CFG_PEAK_COUNT;
        cfg_data  <= CFG_DATA_BITS'(count);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_DEADZONE;
        cfg_data  <= CFG_DATA_BITS'(zone);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_count = count & 31;
        shadow_zone  = zone & 16383;
        n_settings++;
    endtask

    task automatic test_reset_values();
        pattern = '{0, 12, -5, 40, 40, 7};
        send_run();
        settle();
    endtask

    task automatic test_field_extremes();
        program_regs(MAXP, 0);
        pattern = '{8191, -8192, 0, 1, 8191, -1, 8190};
        send_run();
        settle();
    endtask

    task automatic test_ties_and_exclusion();
        program_regs(4, 2);
        pattern = '{3, 7, 7, 1, 7, 0, 5, -3, 9};
        send_run();
        settle();
    endtask

    task automatic test_count_clamp();
        program_regs(0, 16383);
        pattern = '{-4};
        send_run();
        settle();
        program_regs(31, 16383);
        pattern = '{5, -8192};
        send_run();
        settle();
    endtask

    task automatic test_random_buffers();
        int sent, b, nbuf, len, count, zone;
        sent = 0;
        while (sent < 130) begin
            case ($urandom_range(0, 7))
                0: count = 1;
                1: count = MAXP;
                2: count = 0;
                3: count = $urandom_range(MAXP + 1, 31);
                default: count = $urandom_range(1, MAXP);
            endcase
            case ($urandom_range(0, 4))
                0: zone = 0;
                1: zone = 16383;
                2: zone = $urandom_range(0, 16383);
                default: zone = $urandom_range(1, 12);
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            program_regs(count, zone);
            nbuf = $urandom_range(2, 4);
            for (b = 0; b < nbuf; b++) begin
                len = $urandom_range(1, 24);
                send_buffer(len, $urandom_range(0, 3));
                sent += len;
            end
            settle();
        end
    endtask

    task automatic test_quiet_tail();
        int b;
        idle_on = 1'b0;
        program_regs($urandom_range(1, MAXP), $urandom_range(0, 8));
        for (b = 0; b < 3; b++) begin
            send_buffer($urandom_range(4, 20), $urandom_range(0, 2));
        end
        settle();
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        s_tvalid     = 1'b0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_PEAK_COUNT;
        cfg_data     = '0;
        acq_len      = 0;
        shadow_count = int'(PEAK_COUNT_RESET);
        shadow_zone  = int'(DEADZONE_RESET);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_field_extremes();
        test_ties_and_exclusion();
        test_count_clamp();
        test_random_buffers();
        test_quiet_tail();

        repeat (32) @(posedge aclk);
        if (peaks_due.size() != 0) begin
            flag_error($sformatf("%0d peaks never emitted", peaks_due.size()));
        end
        if (errors > 10) begin
            $display("%0d further errors not shown", errors - 10);
        end
        $display("Covered %0d sample transfers in %0d buffers and %0d peak results",
                 n_samples, n_buffers, n_results);
        $display("under %0d register settings, with random stalls on both sides",
                 n_settings);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
